// ----- rtl/core/cra_pkg.sv -----
package cra_pkg;

    localparam int START_W  = 8;
    localparam int LENGTH_W = 9;
    localparam int FILEID_W = 6;
    localparam int STATUS_W = 3;
    localparam int CFG_W    = 9;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;

    localparam logic [CFG_W-1:0] SLOTS_IN_USE_RESET = 9'd256;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_OCCUPIED   = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_OUTSIDE    = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_PLACED = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_TABLE_FULL = 3'd4;

    typedef struct packed {
        logic                placed;
        logic [START_W-1:0]  start;
        logic [LENGTH_W-1:0] length;
    } file_entry_t;

endpackage

// ----- rtl/core/contiguous_range_allocator.sv -----
// Contiguous range allocator. Each word on s_ carries either an allocate request (start, length)
// or a free request (file id); every request gives exactly one result word on m_ with a status
// and the id handed out. A free slot owner map of SLOTS entries and a file table of MAX_FILES
// entries sit in single-port-write memories, and one slot is read or written per cycle, so the
// owner map port pair sets the rate. An allocate that passes the range and occupancy checks
// scans its range and then fills it; an allocate that meets an occupied slot stops at that slot;
// a free of a placed file reads its table entry and then scans its range, clearing the slots it
// owns. A range or table-full reject, or a free of an id not yet handed out, goes straight to the
// result, and a free of a file that is not placed stops after its table entry is read. A result
// still waiting in the output register holds the next request in its last state. s_tready is
// high only between requests. After reset the owner map is swept to zero, one slot at a time,
// during which no request is taken; cfg_we writes are taken at any time and must only be
// issued while no request is in flight.
module contiguous_range_allocator #(
    parameter int SLOTS     = 256,
    parameter int MAX_FILES = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [cra_pkg::CFG_W-1:0]        cfg_wdata,   // slots_in_use
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [cra_pkg::IN_DATA_W-1:0]    s_tdata,     // start_req[7:0], length[16:8],
                                                          // file_id[22:17], zero pad
    input  logic                             s_tuser,     // kind
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [cra_pkg::OUT_DATA_W-1:0]   m_tdata      // status[2:0], assigned_id[8:3],
                                                          // zero pad
);

    localparam int ADDR_W    = $clog2(SLOTS);
    localparam int POS_W     = (ADDR_W > 10) ? ADDR_W : 10;
    localparam int SLOTS_CAP = (SLOTS < 511) ? SLOTS : 511;
    localparam int FID_W     = $clog2(MAX_FILES);
    localparam int NID_W     = $clog2(MAX_FILES + 1);
    localparam int CMP_W     = (NID_W > cra_pkg::FILEID_W) ? NID_W : cra_pkg::FILEID_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FILL,
        ST_FREE_RD,
        ST_FREE_CHK,
        ST_FREE_SCAN,
        ST_DONE
    } state_t;

    state_t                         state_reg, state_next;
    logic [POS_W-1:0]               pos_reg, pos_next;
    logic [POS_W-1:0]               end_reg, end_next;
    logic                           chk_vld_reg, chk_vld_next;
    logic [ADDR_W-1:0]              chk_pos_reg, chk_pos_next;
    logic [NID_W-1:0]               id_reg, id_next;
    logic [NID_W-1:0]               next_id_reg, next_id_next;
    logic [cra_pkg::START_W-1:0]    start_reg, start_next;
    logic [cra_pkg::LENGTH_W-1:0]   len_reg, len_next;
    logic [FID_W-1:0]               fid_reg, fid_next;
    logic [cra_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic [cra_pkg::FILEID_W-1:0]   res_id_reg, res_id_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [cra_pkg::OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [cra_pkg::CFG_W-1:0]      slots_in_use_reg;

    logic [NID_W-1:0]               owner_mem [SLOTS];
    cra_pkg::file_entry_t           file_mem [MAX_FILES];
    logic [NID_W-1:0]               own_rdata_reg;
    cra_pkg::file_entry_t           ft_rdata_reg;

    logic                           own_we;
    logic [ADDR_W-1:0]              own_waddr;
    logic [NID_W-1:0]               own_wdata;
    logic                           ft_we;
    logic [FID_W-1:0]               ft_waddr;
    cra_pkg::file_entry_t           ft_wdata;

    logic [cra_pkg::START_W-1:0]    in_start;
    logic [cra_pkg::LENGTH_W-1:0]   in_len;
    logic [cra_pkg::FILEID_W-1:0]   in_fid;
    logic [POS_W-1:0]               in_end;
    logic [POS_W-1:0]               limit;
    logic [CMP_W-1:0]               in_fid_ext;
    logic [NID_W-1:0]               alloc_tag;
    logic [NID_W-1:0]               free_tag;
    logic                           in_acc;

    assign in_start   = s_tdata[7:0];
    assign in_len     = s_tdata[16:8];
    assign in_fid     = s_tdata[22:17];
    assign in_end     = POS_W'(in_start) + POS_W'(in_len);
    assign limit      = (POS_W'(slots_in_use_reg) < POS_W'(SLOTS_CAP))
                        ? POS_W'(slots_in_use_reg) : POS_W'(SLOTS_CAP);
    assign in_fid_ext = CMP_W'(in_fid);
    assign alloc_tag  = id_reg + NID_W'(1);
    assign free_tag   = NID_W'(fid_reg) + NID_W'(1);
    assign in_acc     = s_tvalid && s_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        end_next      = end_reg;
        chk_vld_next  = chk_vld_reg;
        chk_pos_next  = chk_pos_reg;
        id_next       = id_reg;
        next_id_next  = next_id_reg;
        start_next    = start_reg;
        len_next      = len_reg;
        fid_next      = fid_reg;
        status_next   = status_reg;
        res_id_next   = res_id_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        own_we        = 1'b0;
        own_waddr     = pos_reg[ADDR_W-1:0];
        own_wdata     = '0;
        ft_we         = 1'b0;
        ft_waddr      = id_reg[FID_W-1:0];
        ft_wdata      = '{placed: 1'b0, start: start_reg, length: len_reg};

        unique case (state_reg)
            ST_CLEAR:
            begin
                own_we = 1'b1;
                if (pos_reg[ADDR_W-1:0] == ADDR_W'(SLOTS - 1))
                begin
                    pos_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    start_next   = in_start;
                    len_next     = in_len;
                    res_id_next  = '0;
                    chk_vld_next = 1'b0;
                    if (s_tuser == cra_pkg::KIND_ALLOC)
                    begin
                        if (next_id_reg == NID_W'(MAX_FILES))
                        begin
                            status_next = cra_pkg::STATUS_TABLE_FULL;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            id_next      = next_id_reg;
                            next_id_next = next_id_reg + NID_W'(1);
                            res_id_next  = cra_pkg::FILEID_W'(next_id_reg);
                            pos_next     = POS_W'(in_start);
                            end_next     = in_end;
                            if (in_end > limit)
                            begin
                                ft_we       = 1'b1;
                                ft_waddr    = next_id_reg[FID_W-1:0];
                                ft_wdata    = '{placed: 1'b0, start: in_start, length: in_len};
                                status_next = cra_pkg::STATUS_OUTSIDE;
                                state_next  = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                    end
                    else
                    begin
                        fid_next = in_fid_ext[FID_W-1:0];
                        if (in_fid_ext >= CMP_W'(next_id_reg))
                        begin
                            status_next = cra_pkg::STATUS_NOT_PLACED;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_FREE_RD;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                priority if (chk_vld_reg && own_rdata_reg != '0)
                begin
                    ft_we       = 1'b1;
                    status_next = cra_pkg::STATUS_OCCUPIED;
                    state_next  = ST_DONE;
                end
                else if (pos_reg < end_reg)
                begin
                    pos_next     = pos_reg + POS_W'(1);
                    chk_vld_next = 1'b1;
                end
                else
                begin
                    pos_next     = POS_W'(start_reg);
                    chk_vld_next = 1'b0;
                    state_next   = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (pos_reg < end_reg)
                begin
                    own_we    = 1'b1;
                    own_wdata = alloc_tag;
                    pos_next  = pos_reg + POS_W'(1);
                end
                else
                begin
                    ft_we          = 1'b1;
                    ft_wdata.placed = 1'b1;
                    status_next    = cra_pkg::STATUS_OK;
                    state_next     = ST_DONE;
                end
            end
            ST_FREE_RD:
            begin
                state_next = ST_FREE_CHK;
            end
            ST_FREE_CHK:
            begin
                pos_next     = POS_W'(ft_rdata_reg.start);
                end_next     = POS_W'(ft_rdata_reg.start) + POS_W'(ft_rdata_reg.length);
                chk_vld_next = 1'b0;
                if (ft_rdata_reg.placed)
                begin
                    state_next = ST_FREE_SCAN;
                end
                else
                begin
                    status_next = cra_pkg::STATUS_NOT_PLACED;
                    state_next  = ST_DONE;
                end
            end
            ST_FREE_SCAN:
            begin
                if (chk_vld_reg && own_rdata_reg == free_tag)
                begin
                    own_we    = 1'b1;
                    own_waddr = chk_pos_reg;
                end
                priority if (pos_reg < end_reg)
                begin
                    chk_pos_next = pos_reg[ADDR_W-1:0];
                    pos_next     = pos_reg + POS_W'(1);
                    chk_vld_next = 1'b1;
                end
                else if (chk_vld_reg)
                begin
                    chk_vld_next = 1'b0;
                end
                else
                begin
                    ft_we       = 1'b1;
                    ft_waddr    = fid_reg;
                    ft_wdata    = '0;
                    status_next = cra_pkg::STATUS_OK;
                    state_next  = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {(cra_pkg::OUT_DATA_W - cra_pkg::FILEID_W
                                      - cra_pkg::STATUS_W)'(0), res_id_reg, status_reg};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            pos_reg          <= '0;
            chk_vld_reg      <= 1'b0;
            next_id_reg      <= '0;
            m_tvalid_reg     <= 1'b0;
            m_tdata_reg      <= '0;
            slots_in_use_reg <= cra_pkg::SLOTS_IN_USE_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            chk_vld_reg  <= chk_vld_next;
            next_id_reg  <= next_id_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            if (cfg_we)
            begin
                slots_in_use_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        end_reg     <= end_next;
        chk_pos_reg <= chk_pos_next;
        id_reg      <= id_next;
        start_reg   <= start_next;
        len_reg     <= len_next;
        fid_reg     <= fid_next;
        status_reg  <= status_next;
        res_id_reg  <= res_id_next;
    end

    always_ff @(posedge clk)
    begin
        if (own_we)
        begin
            owner_mem[own_waddr] <= own_wdata;
        end
        own_rdata_reg <= owner_mem[pos_reg[ADDR_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (ft_we)
        begin
            file_mem[ft_waddr] <= ft_wdata;
        end
        ft_rdata_reg <= file_mem[fid_reg];
    end

endmodule

// ----- rtl/core/cra_checker.sv -----
module cra_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [cra_pkg::OUT_DATA_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2:0] <= cra_pkg::STATUS_TABLE_FULL)
        else $error("status code out of range");

    a_no_id_on_reject: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[2:0] == cra_pkg::STATUS_TABLE_FULL
                     || m_tdata[2:0] == cra_pkg::STATUS_NOT_PLACED)
        |-> m_tdata[8:3] == '0)
        else $error("id reported on a request that consumed none");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while another is in flight");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[cra_pkg::OUT_DATA_W-1:9] == '0)
        else $error("result pad bits not zero");

endmodule

bind contiguous_range_allocator cra_checker u_cra_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/sv/contiguous_range_allocator_tb.sv -----
module contiguous_range_allocator_tb;

    localparam int SLOT_COUNT  = 256;
    localparam int FILE_COUNT  = 64;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [cra_pkg::STATUS_W-1:0] status;
        logic [cra_pkg::FILEID_W-1:0] id;
    } alloc_reply_t;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [cra_pkg::CFG_W-1:0]      cfg_wdata = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [cra_pkg::IN_DATA_W-1:0]  s_tdata   = '0;
    logic                           s_tuser   = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [cra_pkg::OUT_DATA_W-1:0] m_tdata;

    logic [6:0]                 slot_owner [SLOT_COUNT];
    cra_pkg::file_entry_t       file_dir [FILE_COUNT];
    logic [6:0]                 ids_issued = '0;
    logic [cra_pkg::CFG_W-1:0]  slot_limit = cra_pkg::SLOTS_IN_USE_RESET;
    alloc_reply_t               expected_replies [$];

    int error_count       = 0;
    int cycle_count       = 0;
    int send_idle_pct     = 0;
    int recv_idle_pct     = 0;
    int recv_hold_cycles  = 0;

    always #2 clk = ~clk;

    contiguous_range_allocator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        foreach (slot_owner[i])
            slot_owner[i] = '0;
        foreach (file_dir[i])
            file_dir[i] = '0;
    end

    function automatic alloc_reply_t predict_reply(
        input logic                          kind,
        input logic [cra_pkg::START_W-1:0]   start,
        input logic [cra_pkg::LENGTH_W-1:0]  len,
        input logic [cra_pkg::FILEID_W-1:0]  fid);
        alloc_reply_t                 reply;
        int unsigned                  stop;
        int unsigned                  usable;
        logic [cra_pkg::FILEID_W-1:0] id;
        bit                           clash;
        reply.status = cra_pkg::STATUS_OK;
        reply.id     = '0;
        if (kind == cra_pkg::KIND_ALLOC)
        begin
            if (ids_issued >= FILE_COUNT)
                reply.status = cra_pkg::STATUS_TABLE_FULL;
            else
            begin
                id         = ids_issued[cra_pkg::FILEID_W-1:0];
                ids_issued = ids_issued + 7'd1;
                reply.id   = id;
                stop       = start + len;
                usable     = (slot_limit > SLOT_COUNT) ? SLOT_COUNT : slot_limit;
                if (stop > usable)
                    reply.status = cra_pkg::STATUS_OUTSIDE;
                else
                begin
                    clash = 1'b0;
                    for (int i = start; i < stop; i++)
                        if (slot_owner[i] != 0)
                            clash = 1'b1;
                    if (clash)
                        reply.status = cra_pkg::STATUS_OCCUPIED;
                    else
                    begin
                        for (int i = start; i < stop; i++)
                            slot_owner[i] = {1'b0, id} + 7'd1;
                        file_dir[id].placed = 1'b1;
                        file_dir[id].start  = start;
                        file_dir[id].length = len;
                    end
                end
            end
        end
        else if (!file_dir[fid].placed)
            reply.status = cra_pkg::STATUS_NOT_PLACED;
        else
        begin
            stop = file_dir[fid].start + file_dir[fid].length;
            if (stop > SLOT_COUNT)
                stop = SLOT_COUNT;
            for (int i = file_dir[fid].start; i < stop; i++)
                if (slot_owner[i] == {1'b0, fid} + 7'd1)
                    slot_owner[i] = '0;
            file_dir[fid].placed = 1'b0;
        end
        return reply;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("mismatch on %s: expected %0d, got %0d", what, want, got);
        error_count++;
    endtask

    task automatic send_request(input logic kind, input logic [cra_pkg::START_W-1:0] start,
                                input logic [cra_pkg::LENGTH_W-1:0] len,
                                input logic [cra_pkg::FILEID_W-1:0] fid);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {1'b0, fid, len, start};
        do
            @(posedge clk);
        while (!s_tready);
        expected_replies.insert(expected_replies.size(), predict_reply(kind, start, len, fid));
    endtask

    // drop valid, drain all replies, then hold until the block takes words again
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_replies.size() != 0 || !s_tready);
    endtask

    task automatic set_slot_limit(input logic [cra_pkg::CFG_W-1:0] value);
        wait_idle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        slot_limit = value;
    endtask

    task automatic send_random_request();
        logic [cra_pkg::FILEID_W-1:0] placed_ids [$];
        logic                         kind;
        logic [cra_pkg::START_W-1:0]  start;
        logic [cra_pkg::LENGTH_W-1:0] len;
        logic [cra_pkg::FILEID_W-1:0] fid;
        int                           pick;
        start = cra_pkg::START_W'($urandom_range(255));
        len   = cra_pkg::LENGTH_W'($urandom_range(511));
        fid   = cra_pkg::FILEID_W'($urandom_range(63));
        kind  = ($urandom_range(99) < 8) ? cra_pkg::KIND_ALLOC : cra_pkg::KIND_FREE;
        pick  = $urandom_range(99);
        if (kind == cra_pkg::KIND_ALLOC)
        begin
            if (pick < 60)
                len = cra_pkg::LENGTH_W'($urandom_range(8, 1));
            else if (pick < 80)
                len = cra_pkg::LENGTH_W'($urandom_range(64, 9));
            else if (pick < 88)
                len = '0;
            else if (pick < 93)
                len = cra_pkg::LENGTH_W'($urandom_range(256, 65));
        end
        else if (pick < 15)
        begin
            foreach (file_dir[i])
                if (file_dir[i].placed)
                    placed_ids.insert(placed_ids.size(), cra_pkg::FILEID_W'(i));
            if (placed_ids.size() != 0)
                fid = placed_ids[$urandom_range(placed_ids.size() - 1)];
        end
        send_request(kind, start, len, fid);
    endtask

    task automatic test_directed_requests();
        send_request(cra_pkg::KIND_FREE, 8'd0, 9'd0, 6'd0);
        send_request(cra_pkg::KIND_FREE, 8'hff, 9'h1ff, 6'd63);
        send_request(cra_pkg::KIND_ALLOC, 8'd0, 9'd0, 6'd0);
        send_request(cra_pkg::KIND_FREE, 8'd0, 9'd0, 6'd0);
        send_request(cra_pkg::KIND_FREE, 8'd0, 9'd0, 6'd0);
        send_request(cra_pkg::KIND_ALLOC, 8'd0, 9'd256, 6'h3f);
        send_request(cra_pkg::KIND_ALLOC, 8'd255, 9'd1, 6'd0);
        send_request(cra_pkg::KIND_FREE, 8'd0, 9'd0, 6'd2);
        send_request(cra_pkg::KIND_ALLOC, 8'd255, 9'd2, 6'd0);
        send_request(cra_pkg::KIND_ALLOC, 8'd0, 9'h1ff, 6'd0);
        send_request(cra_pkg::KIND_FREE, 8'd0, 9'd0, 6'd1);
        send_request(cra_pkg::KIND_ALLOC, 8'd255, 9'd1, 6'd0);
        send_request(cra_pkg::KIND_ALLOC, 8'd0, 9'd255, 6'd0);
        send_request(cra_pkg::KIND_ALLOC, 8'd100, 9'd0, 6'd0);
        send_request(cra_pkg::KIND_FREE, 8'd255, 9'h1ff, 6'd6);
        send_request(cra_pkg::KIND_FREE, 8'd0, 9'd0, 6'd5);
        send_request(cra_pkg::KIND_FREE, 8'd0, 9'd0, 6'd7);
        send_request(cra_pkg::KIND_ALLOC, 8'haa, 9'h055, 6'h2a);
        send_request(cra_pkg::KIND_ALLOC, 8'h55, 9'h0aa, 6'h15);
        send_request(cra_pkg::KIND_FREE, 8'd0, 9'h100, 6'd8);
    endtask

    task automatic test_slot_limit_extremes();
        logic [cra_pkg::FILEID_W-1:0] top_file;
        send_request(cra_pkg::KIND_ALLOC, 8'd250, 9'd6, 6'd0);
        top_file = ids_issued[cra_pkg::FILEID_W-1:0] - 6'd1;
        set_slot_limit(9'd0);
        send_request(cra_pkg::KIND_ALLOC, 8'd0, 9'd0, 6'd0);
        send_request(cra_pkg::KIND_ALLOC, 8'd0, 9'd1, 6'd0);
        send_request(cra_pkg::KIND_ALLOC, 8'd1, 9'd0, 6'd0);
        send_request(cra_pkg::KIND_FREE, 8'd0, 9'd0, top_file);
        set_slot_limit(9'd1);
        send_request(cra_pkg::KIND_ALLOC, 8'd0, 9'd1, 6'd0);
        send_request(cra_pkg::KIND_ALLOC, 8'd0, 9'd2, 6'd0);
        send_request(cra_pkg::KIND_FREE, 8'd0, 9'd0,
                     ids_issued[cra_pkg::FILEID_W-1:0] - 6'd2);
        set_slot_limit(9'h1ff);
        send_request(cra_pkg::KIND_ALLOC, 8'd200, 9'd56, 6'd0);
        send_request(cra_pkg::KIND_ALLOC, 8'd200, 9'd57, 6'd0);
        send_request(cra_pkg::KIND_FREE, 8'd0, 9'd0,
                     ids_issued[cra_pkg::FILEID_W-1:0] - 6'd2);
        set_slot_limit(9'd256);
    endtask

    task automatic test_output_backpressure();
        send_idle_pct    = 0;
        recv_idle_pct    = 0;
        recv_hold_cycles = 400;
        repeat (20)
            send_random_request();
        wait_idle();
    endtask

    task automatic test_random_traffic(input int idle_send, input int idle_recv, input int count);
        send_idle_pct = idle_send;
        recv_idle_pct = idle_recv;
        repeat (count)
            send_random_request();
        wait_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
    endtask

    always @(negedge clk)
    begin
        if (recv_hold_cycles > 0)
        begin
            m_tready <= 1'b0;
            recv_hold_cycles--;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin : check_replies
        alloc_reply_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_replies.size() == 0)
                report_mismatch("unexpected word, status", 0, m_tdata[2:0]);
            else
            begin
                want = expected_replies.pop_front();
                if (m_tdata[2:0] !== want.status)
                    report_mismatch("status", want.status, m_tdata[2:0]);
                if (m_tdata[8:3] !== want.id)
                    report_mismatch("assigned_id", want.id, m_tdata[8:3]);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        repeat (10)
            @(negedge clk);
        rst_n <= 1'b1;
        set_slot_limit(9'd256);
        test_directed_requests();
        test_slot_limit_extremes();
        test_output_backpressure();
        test_random_traffic(15, 82, 380);
        set_slot_limit(cra_pkg::CFG_W'($urandom_range(255, 1)));
        test_random_traffic(82, 15, 380);
        set_slot_limit(9'd256);
        test_random_traffic(0, 0, 380);
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (600)
            @(posedge clk);
        if (expected_replies.size() != 0)
            report_mismatch("words still outstanding", 0, expected_replies.size());
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
